// ===== design/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec package
// Field kinds, extension-field constants and the queued operation record
// shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    // Field kinds carried on the cmd field
    typedef enum logic [2:0] {
        KIND_BYTE = 3'd0,
        KIND_W16  = 3'd1,
        KIND_W24  = 3'd2,
        KIND_W32  = 3'd3,
        KIND_EXT  = 3'd4
    } t_kind;

    // Extension fields carry seven payload bits per byte
    localparam int unsigned EXT_BITS = 7;
    localparam logic [7:0]  EXT_MASK = 8'h7F;

    // One classified item as handed from the front end to the back end
    typedef struct packed {
        logic        dec;    // 1: decode one byte, 0: encode one value
        t_kind       kind;
        logic [31:0] value;
        logic [2:0]  cnt;    // index of the first byte to emit (encode)
    } t_op;

endpackage

`default_nettype wire

// ===== design/sfc_in_if.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec input channel
// Valid/ready channel carrying the field kind and the value or byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] value_in;

    modport source (output valid, output cmd, output value_in, input ready);
    modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

`default_nettype wire

// ===== design/sfc_out_if.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec output channel
// Valid/ready channel carrying one encoded byte or one decoded value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] field_value;
    logic        last;

    modport source (output valid, output data_byte, output field_value, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input field_value, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== design/sfc_front.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec front end
// Accepts input beats, drops undefined kinds and classifies the rest into
// operation records with the index of their first byte to emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_front
    import sfc_pkg::*;
(
    input  wire logic  i_direction,
    sfc_in_if.sink     i_in,
    output logic       o_push,
    output t_op        o_op,
    input  wire logic  i_q_ready
);

    t_kind      kind;
    logic       kind_ok;
    logic [2:0] ext_cnt;

    assign kind = t_kind'(i_in.cmd);

    // Flag defined kinds only
    always_comb begin
        unique case (kind)
            KIND_BYTE, KIND_W16, KIND_W24, KIND_W32, KIND_EXT: kind_ok = 1'b1;
            default:                                           kind_ok = 1'b0;
        endcase
    end

    // Find the highest non-zero 7-bit group of an extension value
    always_comb begin
        if (i_in.value_in[31:28] != '0) begin
            ext_cnt = 3'd4;
        end else if (i_in.value_in[27:21] != '0) begin
            ext_cnt = 3'd3;
        end else if (i_in.value_in[20:14] != '0) begin
            ext_cnt = 3'd2;
        end else if (i_in.value_in[13:7] != '0) begin
            ext_cnt = 3'd1;
        end else begin
            ext_cnt = 3'd0;
        end
    end

    // Build the operation record
    always_comb begin
        o_op.dec   = i_direction;
        o_op.kind  = kind;
        o_op.value = i_in.value_in;
        if (i_direction) begin
            o_op.cnt = 3'd0;
        end else if (kind == KIND_EXT) begin
            o_op.cnt = ext_cnt;
        end else begin
            o_op.cnt = {1'b0, i_in.cmd[1:0]};
        end
    end

    // Accept whenever the queue has room; undefined kinds are consumed and dropped
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready && kind_ok;

endmodule

`default_nettype wire

// ===== design/sfc_queue.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec operation queue
// Small register FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_queue
    import sfc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_ready,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_op            r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfc_back.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec back end
// Works on the queue head: emits encoded bytes one per beat, or folds a
// received byte into the decode accumulator and emits finished values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfc_back
    import sfc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_clear,
    input  wire logic i_valid,
    input  wire t_op  i_op,
    output logic      o_pop,
    sfc_out_if.source o_out
);

    logic        r_started, n_started;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_taken, n_taken;
    logic        r_out_valid;
    logic [7:0]  r_data_byte;
    logic [31:0] r_field_value;
    logic        r_last;

    logic        out_ok;
    logic        step;
    logic [2:0]  idx;
    logic [7:0]  fixed_byte;
    logic [6:0]  ext_group;
    logic [7:0]  enc_byte;
    logic [7:0]  rx_byte;
    logic [31:0] acc_next;
    logic [2:0]  taken_next;
    logic        dec_done;
    logic        emit;
    logic        finish;

    assign out_ok  = !r_out_valid || o_out.ready;
    assign step    = i_valid && out_ok;
    assign idx     = r_started ? r_idx : i_op.cnt;
    assign rx_byte = i_op.value[7:0];

    // Select the encoded byte at the current index
    always_comb begin
        case (idx)
            3'd0:    fixed_byte = i_op.value[7:0];
            3'd1:    fixed_byte = i_op.value[15:8];
            3'd2:    fixed_byte = i_op.value[23:16];
            default: fixed_byte = i_op.value[31:24];
        endcase
        case (idx)
            3'd0:    ext_group = i_op.value[6:0];
            3'd1:    ext_group = i_op.value[13:7];
            3'd2:    ext_group = i_op.value[20:14];
            3'd3:    ext_group = i_op.value[27:21];
            default: ext_group = {3'b000, i_op.value[31:28]};
        endcase
        enc_byte = (i_op.kind == KIND_EXT) ? {idx == 3'd0, ext_group} : fixed_byte;
    end

    // Fold the received byte into the accumulator
    always_comb begin
        taken_next = (r_taken < 3'd7) ? r_taken + 1'b1 : r_taken;
        if (i_op.kind == KIND_EXT) begin
            acc_next = (r_acc << EXT_BITS) + {25'd0, rx_byte[6:0] & EXT_MASK[6:0]};
            dec_done = rx_byte[7];
        end else begin
            acc_next = {r_acc[23:0], rx_byte};
            dec_done = (taken_next >= ({1'b0, i_op.kind[1:0]} + 3'd1));
        end
    end

    assign finish = i_op.dec || (idx == 3'd0);
    assign emit   = step && (!i_op.dec || dec_done);
    assign o_pop  = step && finish;

    // Advance the encode index and decode state
    always_comb begin
        n_started = r_started;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_taken   = r_taken;
        if (step) begin
            if (finish) begin
                n_started = 1'b0;
            end else begin
                n_started = 1'b1;
                n_idx     = idx - 1'b1;
            end
            if (i_op.dec) begin
                n_acc   = dec_done ? '0 : acc_next;
                n_taken = dec_done ? '0 : taken_next;
            end
        end
        if (i_clear) begin
            n_acc   = '0;
            n_taken = '0;
        end
    end

    // Hold control and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_started <= n_started;
            r_idx     <= n_idx;
            r_acc     <= n_acc;
            r_taken   <= n_taken;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output beat
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data_byte   <= i_op.dec ? 8'd0 : enc_byte;
            r_field_value <= i_op.dec ? acc_next : 32'd0;
            r_last        <= i_op.dec || (idx == 3'd0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.data_byte   = r_data_byte;
    assign o_out.field_value = r_field_value;
    assign o_out.last        = r_last;

endmodule

`default_nettype wire

// ===== design/signalling_field_codec_core.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec
// Encodes values into big-endian or 7-bit extension fields, or decodes
// received bytes back into field values, selected by a direction register.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one beat per item (cmd = field kind, value_in = value or byte).
//   o_out : one beat per encoded byte, or one beat per completed decoded value.
//   i_cfg_we / i_cfg_data : write the direction bit (0 encode, 1 decode);
//           write only while the block is idle. A write drops any partial field.
// Timing:
//   The first output beat of an item passes through the queue and then the
//   output register. An encoded item of 1 to 5 bytes holds the back end until
//   its last byte is emitted; a decoded byte is popped as soon as it is folded in.
//   The byte-wide output register sets the encode rate. Items with an
//   undefined kind are accepted and dropped.
// Reset: clears direction to encode, the queue and the decode accumulator.
// Stall: while o_out is held, the back end stops; the queue of QUEUE_DEPTH
//   entries keeps accepting until full, then i_in.ready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signalling_field_codec_core
    import sfc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data,
    sfc_in_if.sink    i_in,
    sfc_out_if.source o_out
);

    logic r_direction;
    logic push;
    t_op  push_op;
    logic q_ready;
    logic q_valid;
    t_op  q_op;
    logic q_pop;

    // Hold the direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_data;
        end
    end

    sfc_front u_front (
        .i_direction (r_direction),
        .i_in        (i_in),
        .o_push      (push),
        .o_op        (push_op),
        .i_q_ready   (q_ready)
    );

    sfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    sfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_valid (q_valid),
        .i_op    (q_op),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Signalling field codec testbench
// Drives field items into the codec in both directions, predicts every
// output beat (encoded bytes or decoded values) and compares each accepted
// beat against the oldest prediction. Covers directed corner cases, random
// well-formed fields mixed with noise, random idling on both channels, a
// long output hold-off and a sender pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import sfc_pkg::*;

    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          PHASE_ITEMS   = 20;
    localparam time         TIMEOUT_NS    = 2_000_000;
    // Kinds outside the defined set; the block drops them
    localparam logic [2:0]  KIND_UNDEF_LO = 3'd5;
    localparam logic [2:0]  KIND_UNDEF_HI = 3'd7;
    localparam logic        DIR_ENCODE    = 1'b0;
    localparam logic        DIR_DECODE    = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] val;
    } t_item;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] field_value;
        logic        last;
    } t_beat;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic cfg_we   = 1'b0;
    logic cfg_data = 1'b0;

    logic        drv_valid = 1'b0;
    logic [2:0]  drv_cmd   = '0;
    logic [31:0] drv_value = '0;
    logic        mon_ready = 1'b0;

    t_item pending_items[$];
    t_beat field_beats_q[$];

    // Codec state as the predictor tracks it
    logic        mdl_decode = 1'b0;
    logic [31:0] mdl_acc    = '0;
    logic [2:0]  mdl_taken  = '0;

    int n_errors      = 0;
    int n_queued      = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req_n    = 0;
    int hold_ack_n    = 0;
    int hold_left     = 0;

    sfc_in_if  in_ch ();
    sfc_out_if out_ch ();

    assign in_ch.valid    = drv_valid;
    assign in_ch.cmd      = drv_cmd;
    assign in_ch.value_in = drv_value;
    assign out_ch.ready   = mon_ready;

    signalling_field_codec_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Work out the beats one accepted item produces and advance the state
    function automatic void predict_field_beats(input logic [2:0] cmd,
                                                input logic [31:0] val);
        int          nbytes;
        int          groups;
        int          i;
        logic [31:0] rest;
        logic [7:0]  b;
        logic        done;
        t_beat       bt;
        if (cmd > KIND_EXT) return;
        bt = '0;
        if (!mdl_decode) begin
            if (cmd != KIND_EXT) begin
                // fixed kinds: low bytes of the value, big-endian
                nbytes = int'(cmd) + 1;
                for (i = nbytes - 1; i >= 0; i--) begin
                    bt.data_byte = 8'(val >> (8 * i));
                    bt.last      = (i == 0);
                    field_beats_q.push_back(bt);
                end
            end else begin
                // extension: 7-bit groups, top group first, flag on the final one
                groups = 1;
                rest   = val >> EXT_BITS;
                while (rest != 0) begin
                    groups++;
                    rest = rest >> EXT_BITS;
                end
                for (i = groups - 1; i >= 0; i--) begin
                    bt.data_byte = 8'((val >> (EXT_BITS * i)) & EXT_MASK);
                    if (i == 0) bt.data_byte[7] = 1'b1;
                    bt.last = (i == 0);
                    field_beats_q.push_back(bt);
                end
            end
        end else begin
            b = val[7:0];
            if (cmd != KIND_EXT) begin
                mdl_acc = {mdl_acc[23:0], b};
                if (mdl_taken < 3'd7) mdl_taken++;
                done = (int'(mdl_taken) >= int'(cmd) + 1);
            end else begin
                mdl_acc = (mdl_acc << EXT_BITS) + {25'd0, b[6:0]};
                if (mdl_taken < 3'd7) mdl_taken++;
                done = b[7];
            end
            if (done) begin
                bt.field_value = mdl_acc;
                bt.last        = 1'b1;
                field_beats_q.push_back(bt);
                mdl_acc   = '0;
                mdl_taken = '0;
            end
        end
    endfunction

    task automatic check_field(input string fname, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
        end
    endtask

    // Driver: present the next pending item, predict on each accepted beat
    always @(posedge clk) begin : item_driver
        t_item nxt;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_ch.ready) begin
                predict_field_beats(drv_cmd, drv_value);
            end
            if (!drv_valid || in_ch.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    drv_valid <= 1'b1;
                    drv_cmd   <= nxt.cmd;
                    drv_value <= nxt.val;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, counted here on request from the stimulus
    always @(posedge clk) begin : out_holdoff
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req_n != hold_ack_n) begin
            hold_left  <= HOLD_CYCLES;
            hold_ack_n <= hold_req_n;
        end
    end

    // Monitor: compare each accepted output beat with the oldest prediction
    always @(posedge clk) begin : beat_monitor
        t_beat want;
        if (!rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (out_ch.valid && mon_ready) begin
                if (field_beats_q.size() == 0) begin
                    n_errors++;
                    $display({"%0t: unexpected beat, expected none, ",
                              "actual byte 0x%0h value 0x%0h last %0b"},
                             $time, out_ch.data_byte, out_ch.field_value, out_ch.last);
                end else begin
                    want = field_beats_q.pop_front();
                    check_field("data_byte", {24'd0, out_ch.data_byte}, {24'd0, want.data_byte});
                    check_field("field_value", out_ch.field_value, want.field_value);
                    check_field("last", {31'd0, out_ch.last}, {31'd0, want.last});
                end
            end
            mon_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(input logic [2:0] cmd, input logic [31:0] val);
        t_item it;
        it.cmd = cmd;
        it.val = val;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    // Hold until every item is accepted and every beat has arrived, then settle
    task automatic wait_drained();
        do @(posedge clk);
        while (pending_items.size() != 0 || drv_valid || field_beats_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= dir;
        @(posedge clk);
        cfg_we     <= 1'b0;
        mdl_decode = dir;
        mdl_acc    = '0;
        mdl_taken  = '0;
    endtask

    // Zero, all-ones, full random and shifted values so extension fields vary in length
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom();
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    task automatic queue_encode_random();
        if ($urandom_range(99) < 6) begin
            queue_item(3'($urandom_range(KIND_UNDEF_HI, KIND_UNDEF_LO)), $urandom());
        end else begin
            queue_item(3'($urandom_range(KIND_EXT)), pick_value());
        end
    endtask

    // One well-formed field of random content, or a noise item
    task automatic queue_decode_random();
        int         nb;
        int         i;
        logic [2:0] kind;
        logic [7:0] b;
        if ($urandom_range(99) < 12) begin
            queue_item(3'($urandom_range(7)), $urandom());
        end else begin
            kind = 3'($urandom_range(KIND_EXT));
            if (kind != KIND_EXT) begin
                for (i = 0; i <= int'(kind); i++) queue_item(kind, $urandom());
            end else begin
                nb = $urandom_range(6, 1);
                for (i = 0; i < nb; i++) begin
                    b = 8'($urandom()) & EXT_MASK;
                    if (i == nb - 1) b[7] = 1'b1;
                    queue_item(KIND_EXT, {24'($urandom()), b});
                end
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        int start;
        int i;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed encode: extremes of each kind, extension lengths, dropped kinds
        set_idling(0);
        write_direction(DIR_ENCODE);
        queue_item(KIND_BYTE, 32'hFFFF_FFFF);
        queue_item(KIND_W16, 32'h0000_0000);
        queue_item(KIND_W24, 32'h89AB_CDEF);
        queue_item(KIND_W32, 32'hFFFF_FFFF);
        queue_item(KIND_EXT, 32'h0000_0000);
        queue_item(KIND_EXT, 32'h0000_007F);
        queue_item(KIND_EXT, 32'h0000_0080);
        queue_item(KIND_EXT, 32'hFFFF_FFFF);
        queue_item(KIND_UNDEF_LO, 32'h1234_5678);
        queue_item(KIND_UNDEF_HI, 32'hFFFF_FFFF);
        wait_drained();

        // Directed decode: upper bits ignored, dropped kind inside a field,
        // extension zero and wrap, kind change inside a field
        write_direction(DIR_DECODE);
        queue_item(KIND_BYTE, 32'hFFFF_FF5A);
        queue_item(KIND_W16, 32'h0000_0012);
        queue_item(KIND_W16, 32'hABCD_0034);
        queue_item(KIND_W24, 32'h0000_00AB);
        queue_item(KIND_UNDEF_LO, 32'h0000_00FF);
        queue_item(KIND_W24, 32'h0000_00CD);
        queue_item(KIND_W24, 32'h0000_00EF);
        queue_item(KIND_EXT, 32'h0000_0080);
        for (i = 0; i < 4; i++) queue_item(KIND_EXT, 32'h0000_007F);
        queue_item(KIND_EXT, 32'h0000_0081);
        queue_item(KIND_W32, 32'h0000_0011);
        queue_item(KIND_BYTE, 32'h0000_0022);
        // leave a partial field, then rewrite the direction to drop it
        queue_item(KIND_W32, 32'h0000_0033);
        wait_drained();
        write_direction(DIR_DECODE);
        queue_item(KIND_W16, 32'h0000_0044);
        queue_item(KIND_W16, 32'h0000_0055);
        wait_drained();

        // Random phases: alternate direction, rotate idling modes
        for (ph = 0; ph < 8; ph++) begin
            set_idling((ph + ph / 4) % 4);
            write_direction(ph[0] ? DIR_DECODE : DIR_ENCODE);
            start = n_queued;
            while (n_queued - start < PHASE_ITEMS) begin
                if (ph[0]) queue_decode_random();
                else queue_encode_random();
            end
            wait_drained();
        end

        // Back-pressure: hold the output while the sender keeps offering
        set_idling(0);
        write_direction(DIR_ENCODE);
        hold_req_n++;
        for (i = 0; i < 16; i++) queue_item(3'($urandom_range(KIND_EXT, KIND_W32)), pick_value());
        wait_drained();

        // Sender pause: stop offering until every beat is back, then resume
        set_idling(3);
        for (i = 0; i < 8; i++) queue_encode_random();
        wait_drained();
        for (i = 0; i < 8; i++) queue_encode_random();
        wait_drained();

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
